[hdl/balance_cascade_controller_macros.svh]
// Assertion macros shared by the balance cascade controller RTL.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef BALANCE_CASCADE_CONTROLLER_MACROS_SVH
`define BALANCE_CASCADE_CONTROLLER_MACROS_SVH

`ifndef SYNTH
// cond must hold at every edge out of reset
`define BCC_ASSERT_ALWAYS(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond)) else $error(msg);
// same-cycle implication
`define BCC_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BCC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) else $error(msg);
`else
`define BCC_ASSERT_ALWAYS(lbl, clk_i, rstn_i, cond, msg)
`define BCC_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons, msg)
`define BCC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg)
`endif

`endif

[hdl/bcc_pkg.sv]
// Types, constants and helper functions for the balance cascade controller.
// No dependencies; used by bcc_mac, bcc_regs and the top level.
package bcc_pkg;

	// shared multiplier operand and accumulator widths
	localparam int A_W    = 25;               // gains (unsigned 24) and small constants
	localparam int B_W    = 27;               // signals, largest is the speed term
	localparam int ACC_W  = A_W + B_W;

	localparam int GAIN_W  = 24;
	localparam int ANGLE_W = 16;
	localparam int SPD_W   = 17;               // speed goal and turn bias
	localparam int IN_W    = 16;
	localparam int OUT_W   = 17;
	localparam int ERR_W   = 18;               // speed error and filtered error
	localparam int INTEG_W = 15;
	localparam int VERT_W  = 19;
	localparam int TURN_W  = 25;
	localparam int MIX_W   = 36;

	// divide by ten: magnitude times ceil(2^24/10), then >> 24; exact below 2^22
	localparam int DIVN_W = 22;
	localparam int MAG_W  = DIVN_W - 1;
	localparam int DIV_SH = 24;
	localparam int Q_W    = ERR_W;

	localparam int PWM_LIMIT   = 7200;
	localparam int INTEG_LIMIT = 10000;

	localparam logic [4:0] SH_Q16 = 5'd16;
	localparam logic [4:0] SH_Q24 = 5'd24;

	typedef logic signed [A_W-1:0]   opa_t;
	typedef logic signed [B_W-1:0]   opb_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam opa_t K_THREE    = A_W'(3);
	localparam opa_t K_SEVEN    = A_W'(7);
	localparam opa_t K_ONE_Q16  = A_W'(65536);
	localparam opa_t K_RECIP_10 = A_W'(1677722);

	localparam logic signed [INTEG_W:0] INTEG_HI = (INTEG_W+1)'(INTEG_LIMIT);
	localparam logic signed [INTEG_W:0] INTEG_LO = -(INTEG_W+1)'(INTEG_LIMIT);
	localparam logic signed [MIX_W-1:0] PWM_HI   = MIX_W'(PWM_LIMIT);
	localparam logic signed [MIX_W-1:0] PWM_LO   = -MIX_W'(PWM_LIMIT);

	// register reset values
	localparam logic [GAIN_W-1:0] RST_VKP = 24'd13107200;
	localparam logic [GAIN_W-1:0] RST_VKD = 24'd353894;
	localparam logic [GAIN_W-1:0] RST_SKP = 24'd43909;
	localparam logic [GAIN_W-1:0] RST_SKI = 24'd220;
	localparam logic [GAIN_W-1:0] RST_TKD = 24'd851968;

	typedef enum logic [2:0] {
		REG_UP_KP,
		REG_UP_KD,
		REG_SPD_KP,
		REG_SPD_KI,
		REG_TURN_KD,
		REG_MID_ANGLE,
		REG_SPD_GOAL,
		REG_TURN_BIAS
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]         up_kp;
		logic [GAIN_W-1:0]         up_kd;
		logic [GAIN_W-1:0]         spd_kp;
		logic [GAIN_W-1:0]         spd_ki;
		logic [GAIN_W-1:0]         turn_kd;
		logic signed [ANGLE_W-1:0] mid_angle;
		logic signed [SPD_W-1:0]   spd_goal;
		logic signed [SPD_W-1:0]   turn_bias;
	} cfg_t;

	typedef struct packed {
		logic issue;   // operands valid this cycle
		logic clr;     // start a new sum
		logic sub;     // subtract the product
	} mac_cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_VKP, S_VKD, S_VWAIT, S_VCAP,
		S_F7, S_FWAIT, S_FDIV, S_FDWAIT, S_FCAP,
		S_PKP, S_PKI, S_PWAIT, S_PCAP,
		S_TBIAS, S_TWAIT, S_TCAP,
		S_MKP, S_MWAIT, S_MCAP,
		S_OUT
	} state_t;

	function automatic opa_t gain_op(input logic [GAIN_W-1:0] g);
		return $signed({1'b0, g});
	endfunction

	// arithmetic shift right that truncates toward zero
	function automatic acc_t rnd_zero(input acc_t v, input logic [4:0] sh);
		acc_t bias;
		bias = v[ACC_W-1] ? ((acc_t'(1) <<< sh) - acc_t'(1)) : '0;
		return (v + bias) >>> sh;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_pwm(input logic signed [MIX_W-1:0] v);
		logic signed [MIX_W-1:0] r;
		if (v > PWM_HI) begin
			r = PWM_HI;
		end else if (v < PWM_LO) begin
			r = PWM_LO;
		end else begin
			r = v;
		end
		return OUT_W'(r);
	endfunction

endpackage

[hdl/bcc_mac.sv]
// Shared multiply-accumulate unit: registered 25x27 signed product, then accumulate.
// Depends on bcc_pkg. After the last issue the sum passes the product register, then the accumulator register.
module bcc_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  bcc_pkg::mac_cmd_t cmd,
	input  bcc_pkg::opa_t     op_a,
	input  bcc_pkg::opb_t     op_b,
	output bcc_pkg::acc_t     acc
);
	import bcc_pkg::*;

	acc_t     prod_s1;
	mac_cmd_t cmd_s1;
	acc_t     acc_q;
	acc_t     base;
	acc_t     term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	assign base = cmd_s1.clr ? '0 : acc_q;
	assign term = cmd_s1.sub ? -prod_s1 : prod_s1;

	always_ff @(posedge clk) begin
		if (cmd_s1.issue) begin
			acc_q <= base + term;
		end
	end

	assign acc = acc_q;

endmodule

[hdl/bcc_regs.sv]
// APB register file holding the gains, balance angle, speed goal and turn bias.
// Depends on bcc_pkg for the register map and the cfg_t bundle.
module bcc_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output bcc_pkg::cfg_t cfg
);
	import bcc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_kp     <= RST_VKP;
			cfg_q.up_kd     <= RST_VKD;
			cfg_q.spd_kp    <= RST_SKP;
			cfg_q.spd_ki    <= RST_SKI;
			cfg_q.turn_kd   <= RST_TKD;
			cfg_q.mid_angle <= '0;
			cfg_q.spd_goal  <= '0;
			cfg_q.turn_bias <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_UP_KP:     cfg_q.up_kp     <= pwdata[GAIN_W-1:0];
				REG_UP_KD:     cfg_q.up_kd     <= pwdata[GAIN_W-1:0];
				REG_SPD_KP:    cfg_q.spd_kp    <= pwdata[GAIN_W-1:0];
				REG_SPD_KI:    cfg_q.spd_ki    <= pwdata[GAIN_W-1:0];
				REG_TURN_KD:   cfg_q.turn_kd   <= pwdata[GAIN_W-1:0];
				REG_MID_ANGLE: cfg_q.mid_angle <= pwdata[ANGLE_W-1:0];
				REG_SPD_GOAL:  cfg_q.spd_goal  <= pwdata[SPD_W-1:0];
				REG_TURN_BIAS: cfg_q.turn_bias <= pwdata[SPD_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_UP_KP:     prdata = 32'(cfg_q.up_kp);
			REG_UP_KD:     prdata = 32'(cfg_q.up_kd);
			REG_SPD_KP:    prdata = 32'(cfg_q.spd_kp);
			REG_SPD_KI:    prdata = 32'(cfg_q.spd_ki);
			REG_TURN_KD:   prdata = 32'(cfg_q.turn_kd);
			REG_MID_ANGLE: prdata = 32'($unsigned(cfg_q.mid_angle));
			REG_SPD_GOAL:  prdata = 32'($unsigned(cfg_q.spd_goal));
			REG_TURN_BIAS: prdata = 32'($unsigned(cfg_q.turn_bias));
		endcase
	end

	assign cfg = cfg_q;

endmodule

[hdl/balance_cascade_controller.sv]
// Two-wheel balance controller: PD upright loop, filtered PI speed loop and steering
// term, mixed into two motor drives saturated to +-PWM_LIMIT. A fresh tick is worked
// through the one shared 25x27 multiply-accumulate unit, which the sequencer runs
// through eleven products, each sum being read once it has passed the unit's product
// and accumulator registers. A tick with attitude_fresh low is accepted and gives no
// word. A finished word waits in the output register; the next fresh tick stalls in
// its last step until that word has been handed over.
// Depends on bcc_pkg, bcc_mac, bcc_regs and balance_cascade_controller_macros.svh.
`include "balance_cascade_controller_macros.svh"

module balance_cascade_controller (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	// roll_angle, roll_rate, yaw_rate, encoder_left_raw, right wheel count (16 bits each)
	input  logic [79:0] s_tdata,
	// attitude_fresh
	input  logic [0:0]  s_tuser,
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	// motor_left (17), motor_right (17), zero pad (6)
	output logic [39:0] m_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bcc_pkg::*;

	cfg_t     cfg;
	state_t   state_q, state_d;
	mac_cmd_t cmd;
	opa_t     op_a;
	opb_t     op_b;
	acc_t     acc;

	// latched tick
	logic signed [IN_W-1:0] angle_q, rate_q, yaw_q, left_q, right_q;

	// loop state
	logic signed [ERR_W-1:0]   filt_q;
	logic signed [INTEG_W-1:0] integ_q;

	// intermediate terms
	logic signed [VERT_W-1:0] vert_q;
	opb_t                     vel_q;
	logic signed [TURN_W-1:0] turn_q;
	logic signed [MIX_W-1:0]  mix_q;
	logic                     neg_q;

	logic signed [OUT_W-1:0] motor_left_q, motor_right_q;
	logic                    m_tvalid_q;

	logic                      s_acc;
	logic                      out_free;
	logic signed [SPD_W:0]     ang_err;
	logic signed [ERR_W-1:0]   spd_err;
	logic signed [DIVN_W-1:0]  div_num;
	logic [MAG_W-1:0]          div_mag;
	logic [Q_W-1:0]            quot;
	logic signed [ERR_W-1:0]   filt_next;
	logic signed [ERR_W:0]     integ_sum;
	logic signed [INTEG_W:0]   integ_next;
	logic signed [MIX_W-1:0]   mix_l, mix_r;

	bcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// small datapath around the shared unit
	assign ang_err = (SPD_W+1)'(angle_q) - (SPD_W+1)'(cfg.mid_angle);
	// left count is negated, so right + left becomes right - left_raw
	assign spd_err = ERR_W'(right_q) - ERR_W'(left_q) - ERR_W'(cfg.spd_goal);
	assign div_num = acc[DIVN_W-1:0];
	assign div_mag = div_num[DIVN_W-1] ? MAG_W'(-div_num) : MAG_W'(div_num);
	assign quot    = acc[DIV_SH +: Q_W];
	assign filt_next = neg_q ? -$signed(quot) : $signed(quot);
	// the filtered error spans 18 bits, so the sum is taken one bit wider
	assign integ_sum = (ERR_W+1)'(integ_q) + (ERR_W+1)'(filt_next);
	assign integ_next = (integ_sum > (ERR_W+1)'(INTEG_HI)) ? INTEG_HI :
		(integ_sum < (ERR_W+1)'(INTEG_LO)) ? INTEG_LO : (INTEG_W+1)'(integ_sum);
	assign mix_l = mix_q - MIX_W'(turn_q);
	assign mix_r = mix_q + MIX_W'(turn_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: a wait state lies between each last product and the state that reads its sum
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		op_a    = '0;
		op_b    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc && s_tuser[0]) state_d = S_VKP;
			end
			S_VKP: begin
				cmd     = '{issue: 1'b1, clr: 1'b1, sub: 1'b0};
				op_a    = gain_op(cfg.up_kp);
				op_b    = B_W'(ang_err);
				state_d = S_VKD;
			end
			S_VKD: begin
				cmd     = '{issue: 1'b1, clr: 1'b0, sub: 1'b0};
				op_a    = gain_op(cfg.up_kd);
				op_b    = B_W'(rate_q);
				state_d = S_VWAIT;
			end
			S_VWAIT: state_d = S_VCAP;
			S_VCAP: begin
				cmd     = '{issue: 1'b1, clr: 1'b1, sub: 1'b0};
				op_a    = K_THREE;
				op_b    = B_W'(spd_err);
				state_d = S_F7;
			end
			S_F7: begin
				cmd     = '{issue: 1'b1, clr: 1'b0, sub: 1'b0};
				op_a    = K_SEVEN;
				op_b    = B_W'(filt_q);
				state_d = S_FWAIT;
			end
			S_FWAIT: state_d = S_FDIV;
			S_FDIV: begin
				cmd     = '{issue: 1'b1, clr: 1'b1, sub: 1'b0};
				op_a    = K_RECIP_10;
				op_b    = B_W'({1'b0, div_mag});
				state_d = S_FDWAIT;
			end
			S_FDWAIT: state_d = S_FCAP;
			S_FCAP:   state_d = S_PKP;
			S_PKP: begin
				cmd     = '{issue: 1'b1, clr: 1'b1, sub: 1'b0};
				op_a    = gain_op(cfg.spd_kp);
				op_b    = B_W'(filt_q);
				state_d = S_PKI;
			end
			S_PKI: begin
				cmd     = '{issue: 1'b1, clr: 1'b0, sub: 1'b0};
				op_a    = gain_op(cfg.spd_ki);
				op_b    = B_W'(integ_q);
				state_d = S_PWAIT;
			end
			S_PWAIT: state_d = S_PCAP;
			S_PCAP: begin
				cmd     = '{issue: 1'b1, clr: 1'b1, sub: 1'b0};
				op_a    = gain_op(cfg.turn_kd);
				op_b    = B_W'(yaw_q);
				state_d = S_TBIAS;
			end
			S_TBIAS: begin
				cmd     = '{issue: 1'b1, clr: 1'b0, sub: 1'b0};
				op_a    = K_ONE_Q16;
				op_b    = B_W'(cfg.turn_bias);
				state_d = S_TWAIT;
			end
			S_TWAIT: state_d = S_TCAP;
			S_TCAP: begin
				cmd     = '{issue: 1'b1, clr: 1'b1, sub: 1'b0};
				op_a    = K_ONE_Q16;
				op_b    = B_W'(vert_q);
				state_d = S_MKP;
			end
			S_MKP: begin
				cmd     = '{issue: 1'b1, clr: 1'b0, sub: 1'b1};
				op_a    = gain_op(cfg.up_kp);
				op_b    = vel_q;
				state_d = S_MWAIT;
			end
			S_MWAIT: state_d = S_MCAP;
			S_MCAP:  state_d = S_OUT;
			S_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			angle_q <= s_tdata[15:0];
			rate_q  <= s_tdata[31:16];
			yaw_q   <= s_tdata[47:32];
			left_q  <= s_tdata[63:48];
			right_q <= s_tdata[79:64];
		end
		if (state_q == S_VCAP) vert_q <= VERT_W'(rnd_zero(acc, SH_Q24));
		if (state_q == S_FDIV) neg_q  <= div_num[DIVN_W-1];
		if (state_q == S_PCAP) vel_q  <= B_W'(rnd_zero(acc, SH_Q16));
		if (state_q == S_TCAP) turn_q <= TURN_W'(rnd_zero(acc, SH_Q16));
		if (state_q == S_MCAP) mix_q  <= MIX_W'(rnd_zero(acc, SH_Q16));
		if (state_q == S_OUT && out_free) begin
			motor_left_q  <= sat_pwm(mix_l);
			motor_right_q <= sat_pwm(mix_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q  <= '0;
			integ_q <= '0;
		end else if (state_q == S_FCAP) begin
			filt_q  <= filt_next;
			integ_q <= INTEG_W'(integ_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, motor_right_q, motor_left_q};

	`BCC_ASSERT_ALWAYS(a_integ_range, clk, arst_n, (INTEG_W+1)'(integ_q) <= INTEG_HI && (INTEG_W+1)'(integ_q) >= INTEG_LO, "speed integral outside clamp")
	`BCC_ASSERT_IMPLY(a_out_sat, clk, arst_n, m_tvalid_q, MIX_W'(motor_left_q) <= PWM_HI && MIX_W'(motor_left_q) >= PWM_LO && MIX_W'(motor_right_q) <= PWM_HI && MIX_W'(motor_right_q) >= PWM_LO, "motor drive beyond limit")
	`BCC_ASSERT_NEXT(a_stale_idle, clk, arst_n, s_acc && !s_tuser[0], state_q == S_IDLE, "stale tick started work")

endmodule
